// ----- rtl/mbde_pkg.sv -----
// ----------------------------------------------------------------------------
// mbde_pkg
// Shared constants and types for the multi-button debouncer: the poll token
// that travels along the row of button cells, event words and register codes.
// ----------------------------------------------------------------------------
package mbde_pkg;

  localparam int unsigned NUM_BUTTONS = 6;   // cells in the row
  localparam int unsigned RAW_BITS    = 6;   // raw pin bits carried per poll
  localparam int unsigned IDX_W       = 3;   // button_index field width
  localparam int unsigned LIMIT_W     = 3;   // max_events field width
  localparam int unsigned TIME_W      = 32;  // millisecond time width
  localparam int unsigned DEB_W       = 16;  // debounce register width
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [LIMIT_W-1:0] MAX_RESULTS = LIMIT_W'(6);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = CFG_IDX_W'(1);

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET     = DEB_W'(20);
  localparam logic             ACTIVE_LEVEL_RESET = 1'b0;

  // Poll context handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic [RAW_BITS-1:0] raw;
    logic [TIME_W-1:0]   now;
    logic [LIMIT_W-1:0]  rem;   // events still allowed in this poll
  } tok_t;

  // Event raised by a single cell
  typedef struct packed {
    logic valid;
    logic down;
  } cell_ev_t;

  // Event word with its button index
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             down;
  } evt_t;

  // Status of the event collector
  typedef struct packed {
    logic adv;    // row may shift this cycle
    logic busy;   // an event is held pending
  } coll_st_t;

endpackage

// ----- rtl/mbde_if.sv -----
// ----------------------------------------------------------------------------
// mbde_if
// Valid/ready channels of the debouncer: poll words in, event words out, and
// register writes.
// ----------------------------------------------------------------------------
interface mbde_in_if;
  import mbde_pkg::*;
  logic                valid;
  logic                ready;
  logic [RAW_BITS-1:0] raw_levels;
  logic [TIME_W-1:0]   now_ms;
  logic [LIMIT_W-1:0]  max_events;

  modport source (output valid, raw_levels, now_ms, max_events, input ready);
  modport sink   (input valid, raw_levels, now_ms, max_events, output ready);
endinterface

interface mbde_out_if;
  import mbde_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] button_index;
  logic             is_down;
  logic             last_event;

  modport source (output valid, button_index, is_down, last_event, input ready);
  modport sink   (input valid, button_index, is_down, last_event, output ready);
endinterface

interface mbde_cfg_if;
  import mbde_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/multi_button_debounce_edge_events.sv -----
// ----------------------------------------------------------------------------
// multi_button_debounce_edge_events
// Debouncer for a row of buttons that reports changes of the stable state as
// event words, scanned in button order under a per-poll event limit.
// ----------------------------------------------------------------------------
// A poll word is taken when the block is idle. Its token then walks the row of
// button cells, one cell per cycle while the row is not held, and leaves it
// at the end of the row, where the final event moves into the output register;
// the next poll is taken once the token and the pending event are gone.
// The walk of the token through the cell row paces the polls; a stalled event
// output holds the row while a second event waits, and an event word still in
// the output register does not block the next poll. Events leave in index
// order, the final one of a poll flagged by last_event. Registers are written
// only while no poll is in progress.
// ----------------------------------------------------------------------------
module multi_button_debounce_edge_events import mbde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbde_in_if.sink    poll_i,
  mbde_cfg_if.sink   cfg_i,
  mbde_out_if.source evt_o
);

  logic [DEB_W-1:0] debounce_ms_q;
  logic             active_level_q;

  tok_t             tok0_q;
  tok_t             tok_w   [NUM_BUTTONS+1];
  logic             lvl_w   [NUM_BUTTONS];
  cell_ev_t         cev_w   [NUM_BUTTONS];
  logic [NUM_BUTTONS:0] tok_vld;

  evt_t             evt;
  logic             fin;
  coll_st_t         coll_st;
  logic             poll_acc;
  logic [LIMIT_W-1:0] limit;

  // Accept register writes only between polls
  assign cfg_i.ready = !(|tok_vld) && !coll_st.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q  <= DEBOUNCE_RESET;
      active_level_q <= ACTIVE_LEVEL_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_DEBOUNCE:     debounce_ms_q  <= cfg_i.data[DEB_W-1:0];
        REG_ACTIVE_LEVEL: active_level_q <= cfg_i.data[0];
        default:          ;
      endcase
    end
  end

  // Take a poll only when the row and the collector are empty
  assign poll_i.ready = !(|tok_vld) && !coll_st.busy;
  assign poll_acc     = poll_i.valid && poll_i.ready;
  assign limit        = (poll_i.max_events > MAX_RESULTS) ? MAX_RESULTS
                                                          : poll_i.max_events;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else if (poll_acc) begin
      tok0_q.valid <= 1'b1;
      tok0_q.raw   <= poll_i.raw_levels;
      tok0_q.now   <= poll_i.now_ms;
      tok0_q.rem   <= limit;
    end else if (coll_st.adv) begin
      tok0_q.valid <= 1'b0;
    end
  end

  assign tok_w[0] = tok0_q;

  // Row of button cells
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
    if (g < RAW_BITS) begin : g_raw
      assign lvl_w[g] = tok_w[g].raw[g];
    end else begin : g_noraw
      assign lvl_w[g] = 1'b0;
    end

    mbde_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .adv_i          (coll_st.adv),
      .tok_i          (tok_w[g]),
      .level_i        (lvl_w[g]),
      .debounce_ms_i  (debounce_ms_q),
      .active_level_i (active_level_q),
      .tok_o          (tok_w[g+1]),
      .ev_o           (cev_w[g])
    );
  end

  // Gather token valids and the event of the cell holding the token
  always_comb begin
    evt = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (cev_w[i].valid) begin
        evt.valid = 1'b1;
        evt.idx   = IDX_W'(i);
        evt.down  = cev_w[i].down;
      end
    end
    for (int i = 0; i <= NUM_BUTTONS; i++) begin
      tok_vld[i] = tok_w[i].valid;
    end
  end

  assign fin = tok_w[NUM_BUTTONS].valid;

  mbde_collect u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ev_i   (evt),
    .fin_i  (fin),
    .st_o   (coll_st),
    .evt_o  (evt_o)
  );

  // Checks
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one poll token in the cell row");

  a_busy_after_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_acc |=> !poll_i.ready)
    else $error("poll taken while the previous one is still scanned");

  a_pend_in_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coll_st.busy |-> (|tok_vld))
    else $error("event pending with no poll in progress");

  a_no_ev_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt.valid |-> !fin)
    else $error("cell event seen while the token leaves the row");

endmodule

// ----- rtl/mbde_cell.sv -----
// ----------------------------------------------------------------------------
// mbde_cell
// One button of the row: holds the button's debounce state, scans it when the
// poll token passes by and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module mbde_cell import mbde_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  tok_t             tok_i,
  input  logic             level_i,
  input  logic [DEB_W-1:0] debounce_ms_i,
  input  logic             active_level_i,
  output tok_t             tok_o,
  output cell_ev_t         ev_o
);

  logic              prev_q, prev_d;
  logic [TIME_W-1:0] ct_q, ct_d;
  logic              stable_q, stable_d;
  logic              rep_q;
  tok_t              tok_q, tok_d;

  logic              scan;
  logic              raw_act;
  logic              changed;
  logic              stable_mid;
  logic [TIME_W-1:0] elapsed;

  // Scan only while the poll still has room for events
  assign scan    = tok_i.valid && (tok_i.rem != '0);
  assign raw_act = (level_i == active_level_i);
  assign changed = (raw_act != prev_q);

  // Restart the timer on a raw change, drop a release at once
  always_comb begin
    prev_d     = raw_act;
    ct_d       = changed ? tok_i.now : ct_q;
    stable_mid = (changed && !raw_act) ? 1'b0 : stable_q;
    elapsed    = tok_i.now - ct_d;
    stable_d   = (elapsed >= TIME_W'(debounce_ms_i)) ? prev_d : stable_mid;
  end

  // Raise an event when the stable state differs from the reported one
  assign ev_o.valid = scan && (stable_d != rep_q);
  assign ev_o.down  = stable_d;

  always_comb begin
    tok_d = tok_i;
    if (ev_o.valid) begin
      tok_d.rem = tok_i.rem - LIMIT_W'(1);
    end
  end

  // Advance the token and commit the button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      ct_q     <= '0;
      stable_q <= 1'b0;
      rep_q    <= 1'b0;
      tok_q    <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (scan) begin
        prev_q   <= prev_d;
        ct_q     <= ct_d;
        stable_q <= stable_d;
        rep_q    <= stable_d;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/mbde_collect.sv -----
// ----------------------------------------------------------------------------
// mbde_collect
// Event collector: holds the latest event until the next one or the end of
// the poll shows whether it is the final word, then loads the output register.
// ----------------------------------------------------------------------------
module mbde_collect import mbde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  evt_t       ev_i,
  input  logic       fin_i,
  output coll_st_t   st_o,
  mbde_out_if.source evt_o
);

  evt_t             pend_q;
  logic             out_vld_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_down_q;
  logic             out_last_q;

  logic need_out;
  logic out_free;
  logic adv;

  // Move the pending word out when a newer event or the poll end arrives
  assign need_out = pend_q.valid && (ev_i.valid || fin_i);
  assign out_free = !out_vld_q || evt_o.ready;
  assign adv      = !need_out || out_free;

  // Hold the most recent event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (adv) begin
      if (ev_i.valid) begin
        pend_q <= ev_i;
      end else if (fin_i) begin
        pend_q.valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (need_out && out_free) begin
      out_vld_q <= 1'b1;
    end else if (evt_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (need_out && out_free) begin
      out_idx_q  <= pend_q.idx;
      out_down_q <= pend_q.down;
      out_last_q <= fin_i;
    end
  end

  assign evt_o.valid        = out_vld_q;
  assign evt_o.button_index = out_idx_q;
  assign evt_o.is_down      = out_down_q;
  assign evt_o.last_event   = out_last_q;

  assign st_o.adv  = adv;
  assign st_o.busy = pend_q.valid;

endmodule

// ----- verif/debounce_event_checker.sv -----
// ----------------------------------------------------------------------------
// debounce_event_checker
// Watches the poll, register and event channels of the debouncer. For each
// accepted poll word it works out the event words the row must emit and
// compares every accepted event word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module debounce_event_checker import mbde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mbde_in_if   poll_i,
  mbde_out_if  evt_i,
  mbde_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             down;
    logic             last;
  } btn_event_t;

  // Register copies
  logic [DEB_W-1:0]       hold_ms;
  logic                   press_level;

  // Per-button debounce state
  logic [NUM_BUTTONS-1:0] seen_active;
  logic [NUM_BUTTONS-1:0] settled_active;
  logic [NUM_BUTTONS-1:0] shown_active;
  logic [TIME_W-1:0]      edge_ms [NUM_BUTTONS];

  btn_event_t             events_due [$];
  int                     mismatches = 0;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Scan the buttons in order under the poll's event budget, queue the events
  task automatic debounce_poll(input logic [RAW_BITS-1:0] raw,
                               input logic [TIME_W-1:0]   now,
                               input logic [LIMIT_W-1:0]  lim);
    int          budget;
    int          emitted;
    logic        pin;
    logic        active;
    logic [TIME_W-1:0] held;
    btn_event_t  ev;
    budget  = (lim > MAX_RESULTS) ? int'(MAX_RESULTS) : int'(lim);
    emitted = 0;
    for (int b = 0; b < NUM_BUTTONS && emitted < budget; b++) begin
      pin    = (b < RAW_BITS) ? raw[b] : 1'b0;
      active = (pin == press_level);
      // Restart the timer on a raw change; drop a release at once
      if (active != seen_active[b]) begin
        seen_active[b] = active;
        edge_ms[b]     = now;
        if (!active) begin
          settled_active[b] = 1'b0;
        end
      end
      held = now - edge_ms[b];
      if (held >= TIME_W'(hold_ms)) begin
        settled_active[b] = seen_active[b];
      end
      if (settled_active[b] != shown_active[b]) begin
        shown_active[b] = settled_active[b];
        ev.idx  = IDX_W'(b);
        ev.down = settled_active[b];
        ev.last = 1'b0;
        events_due.push_back(ev);
        emitted++;
      end
    end
    if (emitted > 0) begin
      events_due[$].last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    btn_event_t want;
    if (!rst_ni) begin
      hold_ms        = DEBOUNCE_RESET;
      press_level    = ACTIVE_LEVEL_RESET;
      seen_active    = '0;
      settled_active = '0;
      shown_active   = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        edge_ms[b] = '0;
      end
      events_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // Compare an accepted event word with the oldest one due
      if (evt_i.valid && evt_i.ready) begin
        if (events_due.size() == 0) begin
          report($sformatf("event word with none due: button %0d down %0b last %0b",
                           evt_i.button_index, evt_i.is_down, evt_i.last_event));
        end else begin
          want = events_due.pop_front();
          if (evt_i.button_index !== want.idx) begin
            report($sformatf("button_index got %0d, expected %0d",
                             evt_i.button_index, want.idx));
          end
          if (evt_i.is_down !== want.down) begin
            report($sformatf("is_down of button %0d got %0b, expected %0b",
                             want.idx, evt_i.is_down, want.down));
          end
          if (evt_i.last_event !== want.last) begin
            report($sformatf("last_event of button %0d got %0b, expected %0b",
                             want.idx, evt_i.last_event, want.last));
          end
        end
      end
      // Track register writes
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_DEBOUNCE:     hold_ms     = cfg_i.data[DEB_W-1:0];
          REG_ACTIVE_LEVEL: press_level = cfg_i.data[0];
          default: ;
        endcase
      end
      // Predict the events of an accepted poll word
      if (poll_i.valid && poll_i.ready) begin
        debounce_poll(poll_i.raw_levels, poll_i.now_ms, poll_i.max_events);
      end
      pending_o    <= events_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- verif/tb_multi_button_debounce_edge_events.sv -----
// ----------------------------------------------------------------------------
// tb_multi_button_debounce_edge_events
// Drives poll words and register writes into the debouncer under random
// idling on both sides, with long output hold-offs that back up the row.
// The checker beside the block predicts and compares; this module gives the
// verdict once every event word due has arrived.
// ----------------------------------------------------------------------------
module tb_multi_button_debounce_edge_events;
  timeunit 1ns;
  timeprecision 1ps;
  import mbde_pkg::*;

  // Drain waits out the walk of a poll through the row; allow some margin
  localparam int SETTLE_CYCLES = NUM_BUTTONS + 6;
  localparam int HOLD_OFF      = 200;

  logic clk;
  logic rst_n;
  int   mismatch_total;
  int   events_due;
  int   polls_sent   = 0;
  int   events_taken = 0;

  logic [RAW_BITS-1:0] pins;
  logic [TIME_W-1:0]   clock_ms;
  int                  hold_cur;

  mbde_in_if  poll_if ();
  mbde_out_if evt_if ();
  mbde_cfg_if cfg_if ();

  multi_button_debounce_edge_events dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .poll_i (poll_if),
    .cfg_i  (cfg_if),
    .evt_o  (evt_if)
  );

  debounce_event_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .poll_i       (poll_if),
    .evt_i        (evt_if),
    .cfg_i        (cfg_if),
    .fail_count_o (mismatch_total),
    .pending_o    (events_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one poll word after a random gap and hold it until taken
  task automatic send_poll(input logic [RAW_BITS-1:0] raw,
                           input logic [TIME_W-1:0]   now,
                           input logic [LIMIT_W-1:0]  lim);
    int gap;
    gap = (polls_sent % 50 < 10) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      poll_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_if.valid      <= 1'b1;
    poll_if.raw_levels <= raw;
    poll_if.now_ms     <= now;
    poll_if.max_events <= lim;
    do @(posedge clk); while (!(poll_if.valid && poll_if.ready));
    polls_sent++;
  endtask

  // Drop valid and wait until no event word is due for a quiet stretch
  task automatic drain();
    int quiet;
    poll_if.valid <= 1'b0;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      quiet = (events_due == 0) ? quiet + 1 : 0;
    end
  endtask

  // Write both registers back to back; valid stays high in between
  task automatic set_config(input int deb, input logic level);
    hold_cur     = deb;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_DEBOUNCE;
    cfg_if.data  <= CFG_DATA_W'(deb);
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.index <= REG_ACTIVE_LEVEL;
    cfg_if.data  <= CFG_DATA_W'(level);
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly steady pins with occasional flips and time advancing near the
  // debounce window; now and then a jump in time and pins
  task automatic random_polls(input int count);
    logic [RAW_BITS-1:0] flips;
    logic [LIMIT_W-1:0]  lim;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        clock_ms = $urandom;
        pins     = RAW_BITS'($urandom);
      end else begin
        flips    = RAW_BITS'($urandom & $urandom);
        pins     = pins ^ flips;
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 2 * hold_cur + 2));
      end
      lim = ($urandom_range(0, 9) < 6) ? LIMIT_W'($urandom_range(6, 7))
                                       : LIMIT_W'($urandom_range(0, 5));
      send_poll(pins, clock_ms, lim);
    end
  endtask

  // Event word receiver: random stalls, calm stretches, two long hold-offs
  initial begin
    int gap;
    evt_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = (events_taken % 64 < 16) ? 0 : $urandom_range(0, 10);
      if (events_taken == 40 || events_taken == 150) begin
        gap = HOLD_OFF;
      end
      if (gap != 0) begin
        evt_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      evt_if.ready <= 1'b1;
      do @(posedge clk); while (!(evt_if.valid && evt_if.ready));
      events_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    int   deb;
    logic level;
    rst_n              <= 1'b0;
    poll_if.valid      <= 1'b0;
    poll_if.raw_levels <= '0;
    poll_if.now_ms     <= '0;
    poll_if.max_events <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_DEBOUNCE;
    cfg_if.data        <= '0;
    hold_cur           = int'(DEBOUNCE_RESET);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 20 ms, pressed is a low pin
    send_poll(6'h3F, 32'd0,    3'd6);   // all released, nothing to report
    send_poll(6'h00, 32'd1000, 3'd6);   // all pressed, timers start
    send_poll(6'h00, 32'd1010, 3'd0);   // limit of zero scans nothing
    send_poll(6'h00, 32'd1019, 3'd6);   // one short of the window
    send_poll(6'h00, 32'd1020, 3'd7);   // limit seven behaves as six
    send_poll(6'h3F, 32'd1021, 3'd2);   // releases cut off after two
    send_poll(6'h3F, 32'd1022, 3'd7);   // the rest of the releases
    send_poll(6'h2A, 32'hFFFF_FFF8, 3'd6);
    send_poll(6'h2A, 32'h0000_000B, 3'd6);  // 19 ms across the wrap
    send_poll(6'h2A, 32'h0000_000C, 3'd6);  // 20 ms across the wrap
    send_poll(6'h15, 32'h0000_000D, 3'd1);
    send_poll(6'h15, 32'h0000_0030, 3'd6);
    send_poll(6'h00, 32'hFFFF_FFFF, 3'd3);
    send_poll(6'h00, 32'h0000_0013, 3'd6);
    drain();

    // Zero debounce with an active-high pin
    set_config(0, 1'b1);
    send_poll(6'h3F, 32'd5, 3'd6);
    send_poll(6'h00, 32'd5, 3'd6);
    send_poll(6'h21, 32'd6, 3'd7);
    send_poll(6'h1E, 32'd6, 3'd4);
    drain();

    // Longest debounce, active low
    set_config(65535, 1'b0);
    send_poll(6'h00, 32'h8000_0000, 3'd6);
    send_poll(6'h00, 32'h8000_FFFE, 3'd6);
    send_poll(6'h00, 32'h8000_FFFF, 3'd6);
    send_poll(6'h3F, 32'hFFFF_FFFF, 3'd6);
    drain();

    // Random phases under changing settings
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 3))
        0:       deb = 0;
        1:       deb = $urandom_range(1, 4);
        default: deb = $urandom_range(5, 40);
      endcase
      if (p == 2) begin
        deb = 65535;
      end
      level = 1'($urandom_range(0, 1));
      set_config(deb, level);
      clock_ms = (p == 0) ? 32'hFFFF_FF80 : TIME_W'($urandom);
      pins     = RAW_BITS'($urandom);
      random_polls(48);
      drain();
    end

    if (mismatch_total == 0 && events_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mbde_pkg.sv
rtl/mbde_if.sv
rtl/mbde_cell.sv
rtl/mbde_collect.sv
rtl/multi_button_debounce_edge_events.sv
verif/debounce_event_checker.sv
verif/tb_multi_button_debounce_edge_events.sv
